// ===== rtl/epr_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Euler point rotator.
`default_nettype none
package epr_pkg;

   // Field and arithmetic formats.
   localparam int COORD_WIDTH    = 16;
   localparam int TRIG_FRAC_BITS = 15;
   localparam int ANGLE_WIDTH    = 16;
   localparam int CORDIC_STEPS   = 24;
   localparam int CORDIC_FRAC    = 30;
   localparam int STEP_W         = $clog2(CORDIC_STEPS);
   localparam int CW             = CORDIC_FRAC + 4;
   localparam int ZW             = 26;
   localparam int TW             = TRIG_FRAC_BITS + 2;
   localparam int MW             = TRIG_FRAC_BITS + 3;
   localparam int PW             = 2 * TRIG_FRAC_BITS + 6;
   localparam int AW             = ANGLE_WIDTH + 1;
   localparam int RW             = PW - TRIG_FRAC_BITS;

   // Angle constants in units of 1/64 degree.
   localparam logic [AW-1:0] FULL_TURN          = AW'(23040);
   localparam logic [AW-1:0] TWO_TURNS          = AW'(46080);
   localparam logic [AW-1:0] THREE_TURNS        = AW'(69120);
   localparam logic [AW-1:0] QUARTER_TURN       = AW'(5760);
   localparam logic [AW-1:0] HALF_TURN          = AW'(11520);
   localparam logic [AW-1:0] THREE_QUARTER_TURN = AW'(17280);
   localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [TW-1:0]          trig_val_type;
   typedef logic signed [MW-1:0]          mat_type;
   typedef logic signed [PW-1:0]          prod_type;

   // One CORDIC lane: vector, residual angle and quadrant fold flag.
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 neg;
   } lane_type;

   // The word that moves along the CORDIC chain.
   typedef struct packed {
      lane_type  yaw;
      lane_type  pitch;
      lane_type  roll;
      coord_type px;
      coord_type py;
      coord_type pz;
   } item_type;

   typedef struct packed {
      trig_val_type s;
      trig_val_type c;
   } trig_type;

   // Arctangent of 2^-i in units of 2^-16 degree.
   function automatic logic signed [ZW-1:0] atan_lut(input logic [STEP_W-1:0] idx);
      logic signed [ZW-1:0] r;
      case (idx)
         5'd0:  r = ZW'(2949120);
         5'd1:  r = ZW'(1740967);
         5'd2:  r = ZW'(919879);
         5'd3:  r = ZW'(466945);
         5'd4:  r = ZW'(234379);
         5'd5:  r = ZW'(117306);
         5'd6:  r = ZW'(58666);
         5'd7:  r = ZW'(29335);
         5'd8:  r = ZW'(14668);
         5'd9:  r = ZW'(7334);
         5'd10: r = ZW'(3667);
         5'd11: r = ZW'(1833);
         5'd12: r = ZW'(917);
         5'd13: r = ZW'(458);
         5'd14: r = ZW'(229);
         5'd15: r = ZW'(115);
         5'd16: r = ZW'(57);
         5'd17: r = ZW'(29);
         5'd18: r = ZW'(14);
         5'd19: r = ZW'(7);
         5'd20: r = ZW'(4);
         5'd21: r = ZW'(2);
         5'd22: r = ZW'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

   // Reduce an angle to one turn, fold it into +-90 degrees and seed the lane.
   function automatic lane_type lane_init(input logic signed [ANGLE_WIDTH-1:0] a);
      logic [AW-1:0]        u;
      logic [AW-1:0]        r;
      logic signed [AW-1:0] s;
      lane_type             l;
      u = AW'(a) + TWO_TURNS;
      if (u >= THREE_TURNS) begin
         r = u - THREE_TURNS;
      end else if (u >= TWO_TURNS) begin
         r = u - TWO_TURNS;
      end else if (u >= FULL_TURN) begin
         r = u - FULL_TURN;
      end else begin
         r = u;
      end
      l.neg = 1'b0;
      if (r > QUARTER_TURN && r <= THREE_QUARTER_TURN) begin
         s = $signed(r - HALF_TURN);
         l.neg = 1'b1;
      end else if (r > THREE_QUARTER_TURN) begin
         s = $signed(r - FULL_TURN);
      end else begin
         s = $signed(r);
      end
      l.z = ZW'(s) <<< 10;
      l.x = CORDIC_GAIN;
      l.y = '0;
      return l;
   endfunction

   // One rotation-mode CORDIC iteration.
   function automatic lane_type cordic_step(input lane_type l,
                                            input logic [STEP_W-1:0] idx);
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      lane_type             o;
      xs = l.x >>> idx;
      ys = l.y >>> idx;
      o.neg = l.neg;
      if (!l.z[ZW-1]) begin
         o.x = l.x - ys;
         o.y = l.y + xs;
         o.z = l.z - atan_lut(idx);
      end else begin
         o.x = l.x + ys;
         o.y = l.y - xs;
         o.z = l.z + atan_lut(idx);
      end
      return o;
   endfunction

   // Round one CORDIC value to the trig format, clamp it to +-1 and negate it if folded.
   function automatic trig_val_type trig_round(input logic signed [CW-1:0] v,
                                               input logic neg);
      localparam int SH = CORDIC_FRAC - TRIG_FRAC_BITS;
      logic signed [CW-1:0]    t;
      logic signed [CW-SH-1:0] r;
      trig_val_type            c;
      t = v + (CW'(1) <<< (SH - 1));
      r = t[CW-1:SH];
      if (r > (CW-SH)'(1 << TRIG_FRAC_BITS)) begin
         c = TW'(1 << TRIG_FRAC_BITS);
      end else if (r < -(CW-SH)'(1 << TRIG_FRAC_BITS)) begin
         c = -TW'(1 << TRIG_FRAC_BITS);
      end else begin
         c = TW'(r);
      end
      return neg ? -c : c;
   endfunction

   // Round half up from Q(2F) to Q(F).
   function automatic logic signed [RW-1:0] rnd(input prod_type v);
      prod_type t;
      t = v + (PW'(1) <<< (TRIG_FRAC_BITS - 1));
      return t[PW-1:TRIG_FRAC_BITS];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/epr_cordic_cell.sv =====
// One CORDIC cell: a single iteration for the yaw, pitch and roll lanes.
`default_nettype none
module epr_cordic_cell import epr_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [STEP_W-1:0] step,
   input  wire logic              load,
   input  wire logic              up_valid,
   input  wire item_type          up_word,
   output logic                   dn_valid,
   output item_type               dn_word
);

   logic     valid_ff;
   item_type word_ff;
   item_type word_in;

   // Rotate all three lanes by this cell's step; coordinates ride along.
   always_comb begin
      word_in       = up_word;
      word_in.yaw   = cordic_step(up_word.yaw, step);
      word_in.pitch = cordic_step(up_word.pitch, step);
      word_in.roll  = cordic_step(up_word.roll, step);
   end

   // Valid flag of the cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_valid;
      end
   end

   // Payload of the cell.
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule
`default_nettype wire

// ===== rtl/euler_point_rotator_core.sv =====
// Top level of the Euler point rotator: angle prep, CORDIC chain and matrix pipeline.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | point and yaw, pitch, roll angles
//   rsp     | out       | rsp_valid/rsp_stall | rotated point
//
// A word passes from acceptance to rsp_valid through one angle-reduction stage,
// 24 CORDIC cells, one trig rounding stage, three matrix stages and the output register.
// One word is accepted per cycle unless req_stall is high; the chain is fully pipelined.
// Synchronous reset clears every stage valid flag.
// A stalled result holds the output register; earlier stages keep moving into
// empty slots, and req_stall rises only once the pipeline is full behind it.
`default_nettype none
module euler_point_rotator_core import epr_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [COORD_WIDTH-1:0] req_in_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_in_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_in_z,
   input  wire logic signed [ANGLE_WIDTH-1:0] req_yaw_angle,
   input  wire logic signed [ANGLE_WIDTH-1:0] req_pitch_angle,
   input  wire logic signed [ANGLE_WIDTH-1:0] req_roll_angle,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z
);

   localparam int NSTG = CORDIC_STEPS + 6;
   localparam int ST_T = CORDIC_STEPS + 1;
   localparam int ST_1 = CORDIC_STEPS + 2;
   localparam int ST_2 = CORDIC_STEPS + 3;
   localparam int ST_3 = CORDIC_STEPS + 4;
   localparam int ST_O = CORDIC_STEPS + 5;

   logic [NSTG-1:0] ld;
   logic [NSTG-1:0] vld;

   // A stage loads when it is empty or its successor loads.
   always_comb begin
      ld[NSTG-1] = !vld[NSTG-1] || !rsp_stall;
      for (int i = NSTG - 2; i >= 0; i--) begin
         ld[i] = !vld[i] || ld[i+1];
      end
   end

   assign req_stall = !ld[0];

   // Angle reduction stage.
   logic     prep_valid_ff;
   item_type prep_word_ff;
   item_type prep_word_in;

   always_comb begin
      prep_word_in.yaw   = lane_init(req_yaw_angle);
      prep_word_in.pitch = lane_init(req_pitch_angle);
      prep_word_in.roll  = lane_init(req_roll_angle);
      prep_word_in.px    = req_in_x;
      prep_word_in.py    = req_in_y;
      prep_word_in.pz    = req_in_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (ld[0]) begin
         prep_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         prep_word_ff <= prep_word_in;
      end
   end

   // CORDIC chain.
   logic     cv [0:CORDIC_STEPS];
   item_type cd [0:CORDIC_STEPS];

   assign cv[0]  = prep_valid_ff;
   assign cd[0]  = prep_word_ff;
   assign vld[0] = prep_valid_ff;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
      epr_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (STEP_W'(k)),
         .load     (ld[k+1]),
         .up_valid (cv[k]),
         .up_word  (cd[k]),
         .dn_valid (cv[k+1]),
         .dn_word  (cd[k+1])
      );
      assign vld[k+1] = cv[k+1];
   end

   // Trig rounding stage.
   logic      t_valid_ff;
   trig_type  ty_ff, tp_ff, tr_ff;
   coord_type tx_ff, tyc_ff, tz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
      end else if (ld[ST_T]) begin
         t_valid_ff <= cv[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (ld[ST_T]) begin
         ty_ff.s <= trig_round(cd[CORDIC_STEPS].yaw.y, cd[CORDIC_STEPS].yaw.neg);
         ty_ff.c <= trig_round(cd[CORDIC_STEPS].yaw.x, cd[CORDIC_STEPS].yaw.neg);
         tp_ff.s <= trig_round(cd[CORDIC_STEPS].pitch.y, cd[CORDIC_STEPS].pitch.neg);
         tp_ff.c <= trig_round(cd[CORDIC_STEPS].pitch.x, cd[CORDIC_STEPS].pitch.neg);
         tr_ff.s <= trig_round(cd[CORDIC_STEPS].roll.y, cd[CORDIC_STEPS].roll.neg);
         tr_ff.c <= trig_round(cd[CORDIC_STEPS].roll.x, cd[CORDIC_STEPS].roll.neg);
         tx_ff   <= cd[CORDIC_STEPS].px;
         tyc_ff  <= cd[CORDIC_STEPS].py;
         tz_ff   <= cd[CORDIC_STEPS].pz;
      end
   end

   assign vld[ST_T] = t_valid_ff;

   // First matrix stage: single products and the pitch-roll cross terms.
   logic         m1_valid_ff;
   mat_type      spsr_ff, spcr_ff, r00_ff, r10_ff, r20_ff, r21_ff, r22_ff;
   trig_val_type cy_ff, sy_ff, cr_ff, sr_ff;
   coord_type    m1x_ff, m1y_ff, m1z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (ld[ST_1]) begin
         m1_valid_ff <= t_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[ST_1]) begin
         spsr_ff <= MW'(rnd(PW'(tp_ff.s) * PW'(tr_ff.s)));
         spcr_ff <= MW'(rnd(PW'(tp_ff.s) * PW'(tr_ff.c)));
         r00_ff  <= MW'(rnd(PW'(ty_ff.c) * PW'(tp_ff.c)));
         r10_ff  <= MW'(rnd(PW'(ty_ff.s) * PW'(tp_ff.c)));
         r21_ff  <= MW'(rnd(PW'(tp_ff.c) * PW'(tr_ff.s)));
         r22_ff  <= MW'(rnd(PW'(tp_ff.c) * PW'(tr_ff.c)));
         r20_ff  <= -MW'(tp_ff.s);
         cy_ff   <= ty_ff.c;
         sy_ff   <= ty_ff.s;
         cr_ff   <= tr_ff.c;
         sr_ff   <= tr_ff.s;
         m1x_ff  <= tx_ff;
         m1y_ff  <= tyc_ff;
         m1z_ff  <= tz_ff;
      end
   end

   assign vld[ST_1] = m1_valid_ff;

   // Second matrix stage: the two-term entries.
   logic      m2_valid_ff;
   mat_type   m_ff [0:8];
   coord_type m2x_ff, m2y_ff, m2z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (ld[ST_2]) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[ST_2]) begin
         m_ff[0] <= r00_ff;
         m_ff[1] <= MW'(rnd(PW'(cy_ff) * PW'(spsr_ff) - PW'(sy_ff) * PW'(cr_ff)));
         m_ff[2] <= MW'(rnd(PW'(cy_ff) * PW'(spcr_ff) + PW'(sy_ff) * PW'(sr_ff)));
         m_ff[3] <= r10_ff;
         m_ff[4] <= MW'(rnd(PW'(sy_ff) * PW'(spsr_ff) + PW'(cy_ff) * PW'(cr_ff)));
         m_ff[5] <= MW'(rnd(PW'(sy_ff) * PW'(spcr_ff) - PW'(cy_ff) * PW'(sr_ff)));
         m_ff[6] <= r20_ff;
         m_ff[7] <= r21_ff;
         m_ff[8] <= r22_ff;
         m2x_ff  <= m1x_ff;
         m2y_ff  <= m1y_ff;
         m2z_ff  <= m1z_ff;
      end
   end

   assign vld[ST_2] = m2_valid_ff;

   // Third matrix stage: entry times coordinate products.
   logic     m3_valid_ff;
   prod_type p_ff [0:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_valid_ff <= 1'b0;
      end else if (ld[ST_3]) begin
         m3_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[ST_3]) begin
         for (int r = 0; r < 3; r++) begin
            p_ff[3*r]   <= PW'(m_ff[3*r])   * PW'(m2x_ff);
            p_ff[3*r+1] <= PW'(m_ff[3*r+1]) * PW'(m2y_ff);
            p_ff[3*r+2] <= PW'(m_ff[3*r+2]) * PW'(m2z_ff);
         end
      end
   end

   assign vld[ST_3] = m3_valid_ff;

   // Output stage: sum, round and saturate each row.
   logic                         o_valid_ff;
   logic signed [COORD_WIDTH-1:0] o_in [0:2];
   logic signed [COORD_WIDTH-1:0] o_ff [0:2];
   logic signed [RW-1:0]          row_r [0:2];

   localparam logic signed [RW-1:0] SAT_HI = RW'((1 << (COORD_WIDTH - 1)) - 1);
   localparam logic signed [RW-1:0] SAT_LO = -RW'(1 << (COORD_WIDTH - 1));

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_r[r] = rnd(p_ff[3*r] + p_ff[3*r+1] + p_ff[3*r+2]);
         if (row_r[r] > SAT_HI) begin
            o_in[r] = SAT_HI[COORD_WIDTH-1:0];
         end else if (row_r[r] < SAT_LO) begin
            o_in[r] = SAT_LO[COORD_WIDTH-1:0];
         end else begin
            o_in[r] = row_r[r][COORD_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (ld[ST_O]) begin
         o_valid_ff <= m3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[ST_O]) begin
         o_ff[0] <= o_in[0];
         o_ff[1] <= o_in[1];
         o_ff[2] <= o_in[2];
      end
   end

   assign vld[ST_O] = o_valid_ff;
   assign rsp_valid = o_valid_ff;
   assign rsp_out_x = o_ff[0];
   assign rsp_out_y = o_ff[1];
   assign rsp_out_z = o_ff[2];

endmodule
`default_nettype wire

// ===== tb/euler_point_rotator_core_test.sv =====
// Testbench for the Euler point rotator core: random and directed points against a predictor.
`default_nettype none
module euler_point_rotator_core_test;
   import epr_pkg::*;

   // Expected rotated point.
   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   // Scoreboard of rotated points still owed by the block.
   class rotation_board;
      point_type pending[$];
      int        errors = 0;

      // Half-up rounding from Q(2F) to Q(F).
      function automatic longint round_trig(longint v);
         return (v + (64'sd1 <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
      endfunction

      // Sine and cosine of an angle in 1/64 degree, by rotation-mode CORDIC.
      function automatic void sin_cos(logic signed [15:0] ang, output longint s,
                                      output longint c);
         longint a, x, y, z, xs, ys, one, half;
         longint atan_tab[24];
         bit flip;
         atan_tab = '{2949120, 1740967, 919879, 466945, 234379, 117306, 58666, 29335,
                      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4,
                      2, 1, 0};
         one = 64'sd1 <<< TRIG_FRAC_BITS;
         half = 64'sd1 <<< (CORDIC_FRAC - TRIG_FRAC_BITS - 1);
         a = ang;
         a = ((a % 23040) + 23040) % 23040;
         flip = 0;
         if (a > 5760 && a <= 17280) begin
            a -= 11520;
            flip = 1;
         end else if (a > 17280) begin
            a -= 23040;
         end
         z = a * 1024;
         x = 652032874;
         y = 0;
         for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x -= ys; y += xs; z -= atan_tab[i];
            end else begin
               x += ys; y -= xs; z += atan_tab[i];
            end
         end
         x = (x + half) >>> (CORDIC_FRAC - TRIG_FRAC_BITS);
         y = (y + half) >>> (CORDIC_FRAC - TRIG_FRAC_BITS);
         if (x > one) x = one;
         if (x < -one) x = -one;
         if (y > one) y = one;
         if (y < -one) y = -one;
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      // Round and saturate one accumulated coordinate.
      function automatic coord_type saturate(longint acc);
         longint v;
         v = round_trig(acc);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         return coord_type'(v);
      endfunction

      // Note an accepted word: compute its rotated point.
      function void note_point(coord_type px, coord_type py, coord_type pz,
                               logic signed [15:0] yaw, logic signed [15:0] pitch,
                               logic signed [15:0] roll);
         longint sy, cy, sp, cp, sr, cr, spsr, spcr;
         longint m00, m01, m02, m10, m11, m12, m20, m21, m22, fx, fy, fz;
         point_type p;
         sin_cos(yaw, sy, cy);
         sin_cos(pitch, sp, cp);
         sin_cos(roll, sr, cr);
         fx = px; fy = py; fz = pz;
         spsr = round_trig(sp * sr);
         spcr = round_trig(sp * cr);
         m00 = round_trig(cy * cp);
         m01 = round_trig(cy * spsr - sy * cr);
         m02 = round_trig(cy * spcr + sy * sr);
         m10 = round_trig(sy * cp);
         m11 = round_trig(sy * spsr + cy * cr);
         m12 = round_trig(sy * spcr - cy * sr);
         m20 = -sp;
         m21 = round_trig(cp * sr);
         m22 = round_trig(cp * cr);
         p.x = saturate(m00 * fx + m01 * fy + m02 * fz);
         p.y = saturate(m10 * fx + m11 * fy + m12 * fz);
         p.z = saturate(m20 * fx + m21 * fy + m22 * fz);
         pending.push_back(p);
      endfunction

      // Compare a result word with the oldest expected point.
      function void check_point(coord_type ax, coord_type ay, coord_type az);
         point_type p;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %0d %0d %0d", $time, ax, ay, az);
            errors++;
            return;
         end
         p = pending.pop_front();
         if (ax !== p.x) begin
            $display("%0t: out_x expected %0d actual %0d", $time, p.x, ax);
            errors++;
         end
         if (ay !== p.y) begin
            $display("%0t: out_y expected %0d actual %0d", $time, p.y, ay);
            errors++;
         end
         if (az !== p.z) begin
            $display("%0t: out_z expected %0d actual %0d", $time, p.z, az);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   coord_type req_in_x = '0, req_in_y = '0, req_in_z = '0;
   logic signed [ANGLE_WIDTH-1:0] req_yaw_angle = '0, req_pitch_angle = '0;
   logic signed [ANGLE_WIDTH-1:0] req_roll_angle = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   coord_type rsp_out_x, rsp_out_y, rsp_out_z;
   bit hold_off = 0;
   rotation_board board = new();

   euler_point_rotator_core i_dut (.*);

   always #1 clock = ~clock;

   // Accepted input words go to the scoreboard.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         board.note_point(req_in_x, req_in_y, req_in_z, req_yaw_angle, req_pitch_angle,
                          req_roll_angle);
   end

   // Accepted result words are checked.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_point(rsp_out_x, rsp_out_y, rsp_out_z);
   end

   // Receiver stall pattern, with quiet stretches and one long hold-off.
   initial begin
      int mode;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (80) @(posedge clock);
            hold_off = 0;
            rsp_stall <= 1'b0;
         end else begin
            mode = ($time / 400) % 3;
            if (mode == 0) rsp_stall <= 1'b0;
            else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
            else rsp_stall <= ($urandom_range(0, 1) == 0);
         end
      end
   end

   // Random angle, mostly in range, sometimes the full 16-bit field.
   function automatic logic signed [15:0] pick_angle();
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return 16'sd23040;
         2: return -16'sd23040;
         3: return 16'($signed($urandom_range(0, 8)) * 2880 - 11520);
         default: return 16'($signed($urandom_range(0, 46080)) - 23040);
      endcase
   endfunction

   // Random coordinate, sometimes near the extremes.
   function automatic coord_type pick_coord();
      case ($urandom_range(0, 5))
         0: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
         1: return coord_type'($signed($urandom_range(0, 2000)) - 1000);
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Offer one word and wait until it is taken.
   task automatic send_point(coord_type x, coord_type y, coord_type z,
                             logic signed [15:0] yaw, logic signed [15:0] pitch,
                             logic signed [15:0] roll);
      req_valid <= 1'b1;
      req_in_x <= x; req_in_y <= y; req_in_z <= z;
      req_yaw_angle <= yaw; req_pitch_angle <= pitch; req_roll_angle <= roll;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Lower valid for a random gap.
   task automatic idle_gap();
      int n;
      n = $urandom_range(1, 6);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Stimulus: directed corners, then random bursts.
   initial begin
      logic signed [15:0] corner[10];
      int burst;
      corner = '{16'sd0, 16'sd5760, -16'sd5760, 16'sd11520, 16'sd17280, 16'sd23040,
                 -16'sd23040, 16'sh7fff, 16'sh8000, 16'sd5761};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Yaw alone and pitch alone at the fold and wrap angles.
      for (int i = 0; i < 8; i++) begin
         send_point(16'sd1600, -16'sd800, 16'sd320, corner[i], 16'sd0, 16'sd0);
         send_point(16'sd1600, -16'sd800, 16'sd320, 16'sd0, corner[i+2], 16'sd0);
      end
      // Saturation at both extremes, then a zero point and a point just past the fold.
      send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd2880, 16'sd2880, 16'sd2880);
      send_point(16'sh8000, 16'sh8000, 16'sh8000, 16'sd2880, 16'sd2880, 16'sd2880);
      send_point(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff);
      send_point(16'sh8000, 16'sh7fff, 16'sh8000, -16'sd2880, 16'sd11520, -16'sd23040);
      send_point(16'sd0, 16'sd0, 16'sd0, 16'sd1000, 16'sd2000, 16'sd3000);
      send_point(-16'sd1, 16'sd1, -16'sd1, corner[9], corner[9], corner[9]);
      // Fill the pipeline against a receiver that holds off.
      hold_off = 1;
      repeat (60)
         send_point(pick_coord(), pick_coord(), pick_coord(), pick_angle(), pick_angle(),
                    pick_angle());
      // Random bursts with gaps.
      for (int n = 0; n < 1500; n += burst) begin
         burst = $urandom_range(1, 40);
         repeat (burst)
            send_point(pick_coord(), pick_coord(), pick_coord(), pick_angle(),
                       pick_angle(), pick_angle());
         if ($urandom_range(0, 2) != 0) idle_gap();
      end
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0)
         $display("euler_point_rotator_core_test: clean");
      else
         $display("euler_point_rotator_core_test: errors");
      $finish;
   end

   // Run limit.
   initial begin
      #200000;
      $display("euler_point_rotator_core_test: errors");
      $finish;
   end
endmodule
`default_nettype wire
